@@ design/rbps_pkg.sv @@
// Package for the rational bilinear pixel sampler.
// Holds widths, action and register codes, and small helpers for coordinates.
// No dependencies.
package rbps_pkg;

    // Image limits and derived widths
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Arithmetic widths
    localparam int DEN_W = 17;            // doubled denominator
    localparam int NUM_W = 56;            // signed scaled numerator
    localparam int QUO_W = 8;             // quotient bits kept
    localparam int REM_W = DEN_W + QUO_W; // coordinate divider remainder
    localparam int WT_W  = 2 * DEN_W;     // blend weight
    localparam int ACC_W = WT_W + QUO_W;  // channel accumulator

    localparam logic FMT_XRGB   = 1'b0;
    localparam logic FILT_POINT = 1'b0;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_FORMAT = 3'd2,
        REG_FILTER = 3'd3,
        REG_SURF_X = 3'd4,
        REG_SURF_Y = 3'd5,
        REG_SCALE  = 3'd6
    } cfg_reg_t;

    // Width or height in use: zero counts as one, large values saturate
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        if (v == '0)
            return DIM_W'(1);
        else if (v > maxv)
            return maxv;
        else
            return v;
    endfunction

    // Clamp-to-edge of a quotient, optionally one pixel further on
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] q,
                                                       input logic plus1,
                                                       input logic neg,
                                                       input logic over,
                                                       input logic [COORD_W-1:0] lim);
        logic [COORD_W:0] c;
        c = {1'b0, q} + (COORD_W+1)'(plus1);
        if (neg)
            return '0;
        else if (over)
            return lim;
        else if (c > {1'b0, lim})
            return lim;
        else
            return c[COORD_W-1:0];
    endfunction

    // Dense store address, wrapped to the store size
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [DIM_W-1:0] w);
        logic [ADDR_W:0] a;
        a = (ADDR_W+1)'(y) * (ADDR_W+1)'(w) + (ADDR_W+1)'(x);
        return a[ADDR_W-1:0];
    endfunction

endpackage

@@ design/rational_bilinear_pixel_sampler_top.sv @@
// Top level of the rational bilinear pixel sampler.
// Depends on rbps_pkg; holds the pixel store and the whole sample pipeline.
//
// Load transactions (tuser low) write one 32-bit word into the 64K-word pixel
// store, one per cycle when nothing ahead of them stalls the chain. Sample
// transactions (tuser high) map a rational point onto the image and return one
// pixel. In bilinear mode each sample holds the single port of the pixel store
// for its four neighbor reads, and the coordinate and blend dividers each hold
// it while they produce its quotient bits; in point mode the store port allows
// one per cycle and the blend divider is bypassed, but the coordinate divider
// still holds each sample for all its quotient bits. Each stage holds one
// item and takes a new one only as its last moves on. The store has no
// clearing pass: pixels read before being loaded return undefined data.
// Configuration may be written only while the pipeline is empty.
module rational_bilinear_pixel_sampler_top
    import rbps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // load_index, pixel_word, x_num, y_num, point_denominator, zero pad
    input  logic [151:0] s_tdata,
    // action
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // red, green, blue, alpha
    output logic [31:0]  m_tdata,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic               format_reg, filter_reg;
    logic signed [31:0] surf_x_reg, surf_y_reg;
    logic [3:0]         scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
            format_reg <= FMT_XRGB;
            filter_reg <= ~FILT_POINT;
            surf_x_reg <= '0;
            surf_y_reg <= '0;
            scale_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_FORMAT: format_reg <= cfg_data[0];
                REG_FILTER: filter_reg <= cfg_data[0];
                REG_SURF_X: surf_x_reg <= $signed(cfg_data);
                REG_SURF_Y: surf_y_reg <= $signed(cfg_data);
                REG_SCALE:  scale_reg  <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    logic             is_point;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic [COORD_W-1:0] lim_w, lim_h;

    assign is_point = (filter_reg == FILT_POINT);
    assign eff_w    = eff_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign eff_h    = eff_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign lim_w    = COORD_W'(eff_w - DIM_W'(1));
    assign lim_h    = COORD_W'(eff_h - DIM_W'(1));

    // ------------------------------------------------------------------
    // Handshake chain
    logic a_v_reg, b_v_reg, c_v_reg, e_v_reg, q_v_reg, u_v_reg, m_v_reg;
    logic p_v_reg, s_v_reg, v_v_reg, o_v_reg;
    logic a_rdy, b_rdy, c_rdy, e_rdy, q_rdy, u_rdy, m_rdy, p_rdy, s_rdy, v_rdy, o_rdy;
    logic a_adv, b_adv, c_adv, e_adv, q_adv, u_adv, m_adv, p_adv, s_adv, v_adv;
    logic q_done, m_done, v_done, p_load;
    action_t q_act_reg, m_act_reg, u_act_reg;

    assign o_rdy = !o_v_reg || m_tready;
    assign v_adv = v_v_reg && v_done && o_rdy;
    assign v_rdy = !v_v_reg || v_adv;
    assign s_adv = s_v_reg && v_rdy;
    assign s_rdy = !s_v_reg || s_adv;
    assign p_adv = p_v_reg && s_rdy;
    assign p_rdy = !p_v_reg || p_adv;
    assign m_adv = m_v_reg && m_done && ((m_act_reg == ACT_LOAD) || p_rdy);
    assign m_rdy = !m_v_reg || m_adv;
    assign p_load = m_adv && (m_act_reg == ACT_SAMPLE);
    assign u_adv = u_v_reg && m_rdy;
    assign u_rdy = !u_v_reg || u_adv;
    assign q_adv = q_v_reg && q_done && u_rdy;
    assign q_rdy = !q_v_reg || q_adv;
    assign e_adv = e_v_reg && q_rdy;
    assign e_rdy = !e_v_reg || e_adv;
    assign c_adv = c_v_reg && e_rdy;
    assign c_rdy = !c_v_reg || c_adv;
    assign b_adv = b_v_reg && c_rdy;
    assign b_rdy = !b_v_reg || b_adv;
    assign a_adv = a_v_reg && b_rdy;
    assign a_rdy = !a_v_reg || a_adv;
    assign s_tready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
            u_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            v_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy) a_v_reg <= s_tvalid;
            if (b_rdy) b_v_reg <= a_adv;
            if (c_rdy) c_v_reg <= b_adv;
            if (e_rdy) e_v_reg <= c_adv;
            if (q_rdy) q_v_reg <= e_adv;
            if (u_rdy) u_v_reg <= q_adv;
            if (m_rdy) m_v_reg <= u_adv;
            if (p_rdy) p_v_reg <= p_load;
            if (s_rdy) s_v_reg <= p_adv;
            if (v_rdy) v_v_reg <= s_adv;
            if (o_rdy) o_v_reg <= v_adv;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register, denominator zero taken as one
    action_t            a_act_reg, b_act_reg, c_act_reg, e_act_reg;
    logic [ADDR_W-1:0]  a_idx_reg, b_idx_reg, c_idx_reg, e_idx_reg, q_idx_reg, u_idx_reg;
    logic [31:0]        a_word_reg, b_word_reg, c_word_reg, e_word_reg, q_word_reg, u_word_reg;
    logic signed [40:0] a_xn_reg, a_yn_reg, b_xn_reg, b_yn_reg;
    logic [15:0]        a_d_reg, b_d_reg, c_d_reg;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && a_rdy)
        begin
            a_act_reg  <= action_t'(s_tuser);
            a_idx_reg  <= s_tdata[15:0];
            a_word_reg <= s_tdata[47:16];
            a_xn_reg   <= $signed(s_tdata[88:48]);
            a_yn_reg   <= $signed(s_tdata[129:89]);
            a_d_reg    <= (s_tdata[145:130] == 16'd0) ? 16'd1 : s_tdata[145:130];
        end
    end

    // Stage B: surface origin times denominator
    logic signed [48:0] b_sxd_reg, b_syd_reg;

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_act_reg  <= a_act_reg;
            b_idx_reg  <= a_idx_reg;
            b_word_reg <= a_word_reg;
            b_xn_reg   <= a_xn_reg;
            b_yn_reg   <= a_yn_reg;
            b_d_reg    <= a_d_reg;
            b_sxd_reg  <= surf_x_reg * $signed({1'b0, a_d_reg});
            b_syd_reg  <= surf_y_reg * $signed({1'b0, a_d_reg});
        end
    end

    // Stage C: point relative to the surface origin
    logic signed [49:0] c_lx_reg, c_ly_reg;

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            c_act_reg  <= b_act_reg;
            c_idx_reg  <= b_idx_reg;
            c_word_reg <= b_word_reg;
            c_d_reg    <= b_d_reg;
            c_lx_reg   <= b_xn_reg - b_sxd_reg;
            c_ly_reg   <= b_yn_reg - b_syd_reg;
        end
    end

    // Stage E: scaled numerator and divisor per filter mode
    logic signed [NUM_W-1:0] e_nx_reg, e_ny_reg, px_w, py_w, nx_next, ny_next;
    logic [DEN_W-1:0]        e_den_reg, den_next;

    always_comb
    begin
        px_w = c_lx_reg * $signed({1'b0, scale_reg});
        py_w = c_ly_reg * $signed({1'b0, scale_reg});
        if (is_point)
        begin
            nx_next  = px_w;
            ny_next  = py_w;
            den_next = {1'b0, c_d_reg};
        end
        else
        begin
            // shift by half a pixel: (2*p - d) over 2*d
            nx_next  = (px_w <<< 1) - $signed(NUM_W'(c_d_reg));
            ny_next  = (py_w <<< 1) - $signed(NUM_W'(c_d_reg));
            den_next = {c_d_reg, 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_adv)
        begin
            e_act_reg  <= c_act_reg;
            e_idx_reg  <= c_idx_reg;
            e_word_reg <= c_word_reg;
            e_nx_reg   <= nx_next;
            e_ny_reg   <= ny_next;
            e_den_reg  <= den_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: coordinate divider, two quotient bits per cycle
    logic [REM_W-1:0] q_rx_reg, q_ry_reg, rx_s, ry_s, tq;
    logic [QUO_W-1:0] q_qx_reg, q_qy_reg, qx_s, qy_s;
    logic [DEN_W-1:0] q_den_reg;
    logic [1:0]       q_cnt_reg;
    logic             q_negx_reg, q_ovx_reg, q_negy_reg, q_ovy_reg;
    logic [2:0]       qbit;
    logic             negx_in, negy_in;

    assign negx_in = e_nx_reg[NUM_W-1];
    assign negy_in = e_ny_reg[NUM_W-1];
    assign q_done  = (q_act_reg == ACT_LOAD) || (q_cnt_reg == 2'd3);

    always_comb
    begin
        rx_s = q_rx_reg;
        ry_s = q_ry_reg;
        qx_s = q_qx_reg;
        qy_s = q_qy_reg;
        qbit = '0;
        tq   = '0;
        for (int j = 0; j < 2; j++)
        begin
            qbit = ~{q_cnt_reg, 1'(j)};
            tq   = REM_W'(q_den_reg) << qbit;
            if (rx_s >= tq)
            begin
                rx_s       = rx_s - tq;
                qx_s[qbit] = 1'b1;
            end
            if (ry_s >= tq)
            begin
                ry_s       = ry_s - tq;
                qy_s[qbit] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_cnt_reg <= '0;
        else if (e_adv)
            q_cnt_reg <= '0;
        else if (q_v_reg && !q_done)
            q_cnt_reg <= q_cnt_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (e_adv)
        begin
            q_act_reg  <= e_act_reg;
            q_idx_reg  <= e_idx_reg;
            q_word_reg <= e_word_reg;
            q_den_reg  <= e_den_reg;
            q_negx_reg <= negx_in;
            q_negy_reg <= negy_in;
            q_ovx_reg  <= !negx_in &&
                          (e_nx_reg[NUM_W-2:0] >= (NUM_W-1)'({e_den_reg, 8'd0}));
            q_ovy_reg  <= !negy_in &&
                          (e_ny_reg[NUM_W-2:0] >= (NUM_W-1)'({e_den_reg, 8'd0}));
            q_rx_reg   <= e_nx_reg[REM_W-1:0];
            q_ry_reg   <= e_ny_reg[REM_W-1:0];
            q_qx_reg   <= '0;
            q_qy_reg   <= '0;
        end
        else if (q_v_reg && !q_done)
        begin
            q_rx_reg <= rx_s;
            q_ry_reg <= ry_s;
            q_qx_reg <= qx_s;
            q_qy_reg <= qy_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage U: clamp to edge, neighbor addresses and fractional weights
    logic [ADDR_W-1:0]  u_addr_reg [0:3];
    logic [DEN_W-1:0]   u_wx_reg, u_wy_reg, u_den_reg;
    logic [COORD_W-1:0] x0, x1, y0, y1;

    always_comb
    begin
        x0 = clamp_coord(qx_s, 1'b0, q_negx_reg, q_ovx_reg, lim_w);
        x1 = clamp_coord(qx_s, 1'b1, q_negx_reg, q_ovx_reg, lim_w);
        y0 = clamp_coord(qy_s, 1'b0, q_negy_reg, q_ovy_reg, lim_h);
        y1 = clamp_coord(qy_s, 1'b1, q_negy_reg, q_ovy_reg, lim_h);
    end

    always_ff @(posedge clk)
    begin
        if (q_adv)
        begin
            u_act_reg     <= q_act_reg;
            u_idx_reg     <= q_idx_reg;
            u_word_reg    <= q_word_reg;
            u_den_reg     <= q_den_reg;
            // weights only matter when both neighbors differ
            u_wx_reg      <= (q_negx_reg || q_ovx_reg) ? '0 : rx_s[DEN_W-1:0];
            u_wy_reg      <= (q_negy_reg || q_ovy_reg) ? '0 : ry_s[DEN_W-1:0];
            u_addr_reg[0] <= pix_addr(x0, y0, eff_w);
            u_addr_reg[1] <= pix_addr(x1, y0, eff_w);
            u_addr_reg[2] <= pix_addr(x0, y1, eff_w);
            u_addr_reg[3] <= pix_addr(x1, y1, eff_w);
        end
    end

    // ------------------------------------------------------------------
    // Stage M: pixel store, one access per cycle
    logic [31:0]       pix_mem [0:STORE_DEPTH-1];
    logic [31:0]       ram_q_reg;
    logic [ADDR_W-1:0] m_addr_reg [0:3];
    logic [31:0]       m_px_reg [0:2];
    logic [DEN_W-1:0]  m_wx_reg, m_wy_reg, m_den_reg;
    logic [2:0]        m_cnt_reg;
    logic              m_rd_more, mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;

    // remaining neighbor reads of a bilinear sample
    assign m_rd_more = m_v_reg && (m_act_reg == ACT_SAMPLE) && !is_point &&
                       (m_cnt_reg != 3'd4);
    assign m_done    = (m_act_reg == ACT_LOAD) || is_point || (m_cnt_reg == 3'd4);
    assign mem_we    = u_adv && (u_act_reg == ACT_LOAD);
    assign mem_re    = (u_adv && (u_act_reg == ACT_SAMPLE)) || m_rd_more;

    always_comb
    begin
        if (u_adv)
            mem_addr = (u_act_reg == ACT_LOAD) ? u_idx_reg : u_addr_reg[0];
        else
            mem_addr = m_addr_reg[m_cnt_reg[1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pix_mem[mem_addr] <= u_word_reg;
        if (mem_re)
            ram_q_reg <= pix_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_cnt_reg <= '0;
        else if (u_adv)
            m_cnt_reg <= 3'd1;
        else if (m_rd_more)
            m_cnt_reg <= m_cnt_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (u_adv)
        begin
            m_act_reg <= u_act_reg;
            m_wx_reg  <= u_wx_reg;
            m_wy_reg  <= u_wy_reg;
            m_den_reg <= u_den_reg;
            for (int k = 0; k < 4; k++)
                m_addr_reg[k] <= u_addr_reg[k];
        end
        if (m_rd_more)
            m_px_reg[2'(m_cnt_reg - 3'd1)] <= ram_q_reg;
    end

    // ------------------------------------------------------------------
    // Stage P: neighbor words and bilinear weights
    logic [31:0]      p_px_reg [0:3];
    logic [WT_W-1:0]  p_w_reg [0:3];
    logic [WT_W-1:0]  p_dd_reg;
    logic [DEN_W-1:0] ix, iy;

    assign ix = m_den_reg - m_wx_reg;
    assign iy = m_den_reg - m_wy_reg;

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_px_reg[0] <= is_point ? ram_q_reg : m_px_reg[0];
            p_px_reg[1] <= m_px_reg[1];
            p_px_reg[2] <= m_px_reg[2];
            p_px_reg[3] <= ram_q_reg;
            p_w_reg[0]  <= WT_W'(ix) * WT_W'(iy);
            p_w_reg[1]  <= WT_W'(m_wx_reg) * WT_W'(iy);
            p_w_reg[2]  <= WT_W'(ix) * WT_W'(m_wy_reg);
            p_w_reg[3]  <= WT_W'(m_wx_reg) * WT_W'(m_wy_reg);
            p_dd_reg    <= WT_W'(m_den_reg) * WT_W'(m_den_reg);
        end
    end

    // Stage S: weighted sums per channel plus half the divisor for rounding
    logic [ACC_W-1:0] s_acc_reg [0:3];
    logic [ACC_W-1:0] acc_next [0:3];
    logic [WT_W-1:0]  s_dd_reg;
    logic [31:0]      s_px0_reg;

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            acc_next[ch] = ACC_W'(p_dd_reg >> 1);
            for (int k = 0; k < 4; k++)
                acc_next[ch] = acc_next[ch] +
                               ACC_W'(p_px_reg[k][8*ch +: 8]) * ACC_W'(p_w_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            s_dd_reg  <= p_dd_reg;
            s_px0_reg <= p_px_reg[0];
            for (int ch = 0; ch < 4; ch++)
                s_acc_reg[ch] <= acc_next[ch];
        end
    end

    // ------------------------------------------------------------------
    // Stage V: blend divider, two quotient bits per cycle on all channels
    logic [ACC_W-1:0] v_rem_reg [0:3];
    logic [ACC_W-1:0] vrem_s [0:3];
    logic [QUO_W-1:0] v_q_reg [0:3];
    logic [QUO_W-1:0] vq_s [0:3];
    logic [WT_W-1:0]  v_dd_reg;
    logic [31:0]      v_px0_reg;
    logic [1:0]       v_cnt_reg;
    logic [2:0]       vbit;
    logic [ACC_W-1:0] tv;

    assign v_done = is_point || (v_cnt_reg == 2'd3);

    always_comb
    begin
        vbit = '0;
        tv   = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            vrem_s[ch] = v_rem_reg[ch];
            vq_s[ch]   = v_q_reg[ch];
        end
        for (int j = 0; j < 2; j++)
        begin
            vbit = ~{v_cnt_reg, 1'(j)};
            tv   = ACC_W'(v_dd_reg) << vbit;
            for (int ch = 0; ch < 4; ch++)
            begin
                if (vrem_s[ch] >= tv)
                begin
                    vrem_s[ch]     = vrem_s[ch] - tv;
                    vq_s[ch][vbit] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_cnt_reg <= '0;
        else if (s_adv)
            v_cnt_reg <= '0;
        else if (v_v_reg && !v_done)
            v_cnt_reg <= v_cnt_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s_adv)
        begin
            v_dd_reg  <= s_dd_reg;
            v_px0_reg <= s_px0_reg;
            for (int ch = 0; ch < 4; ch++)
            begin
                v_rem_reg[ch] <= s_acc_reg[ch];
                v_q_reg[ch]   <= '0;
            end
        end
        else if (v_v_reg && !v_done)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                v_rem_reg[ch] <= vrem_s[ch];
                v_q_reg[ch]   <= vq_s[ch];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: red, green, blue, alpha from the low bits up
    logic [31:0] o_data_reg, o_data_next;
    logic [7:0]  alpha_next;

    always_comb
    begin
        if (is_point)
        begin
            alpha_next  = (format_reg == FMT_XRGB) ? 8'hFF : v_px0_reg[31:24];
            o_data_next = {alpha_next, v_px0_reg[7:0], v_px0_reg[15:8], v_px0_reg[23:16]};
        end
        else
        begin
            alpha_next  = (format_reg == FMT_XRGB) ? 8'hFF : vq_s[3];
            o_data_next = {alpha_next, vq_s[0], vq_s[1], vq_s[2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_adv)
            o_data_reg <= o_data_next;
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = o_data_reg;

endmodule
